FILE: hdl/imm_pkg.sv
// shared types, sizes and codes for the integer matrix multiply block
// no dependencies; imported by imm_ctrl, imm_datapath and the top level
package imm_pkg;

    localparam int MAX_DIM   = 8;
    localparam int IDX_W     = $clog2(MAX_DIM);
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int MEM_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ELEM_W    = 16;
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int SUM_W     = 35;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int OP_W      = 2;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(MAX_DIM);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHARED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 2'd2;

    // operation codes
    localparam logic [OP_W-1:0] OP_WR_A    = 2'd0;
    localparam logic [OP_W-1:0] OP_WR_B    = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

    typedef struct packed {
        logic              wr_a;
        logic              wr_b;
        logic              rd_en;
        logic [ADDR_W-1:0] a_addr;
        logic [ADDR_W-1:0] b_addr;
        logic              first;
        logic              last;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic              run_last;
    } imm_cmd_t;

    typedef struct packed {
        logic out_free;
        logic res_load;
    } imm_stat_t;

    // size register to last usable index: 0 acts as 1, above MAX_DIM acts as MAX_DIM
    function automatic logic [IDX_W-1:0] last_index(input logic [CFG_W-1:0] v);
        logic [IDX_W-1:0] r;
        if (v == '0) begin
            r = '0;
        end else if (v > CFG_W'(MAX_DIM)) begin
            r = IDX_W'(MAX_DIM - 1);
        end else begin
            r = IDX_W'(v - 1'b1);
        end
        return r;
    endfunction

endpackage

FILE: hdl/integer_matrix_multiply.sv
// Signed integer matrix multiply C = A x B, element memories of MAX_DIM x MAX_DIM.
// Input items on s_*: s_tuser is the operation (write A, write B, compute).
// Write items store one 16-bit element of A or B at (row, col); they
// produce no result. A compute item makes the block emit every element of C in
// row-major order on m_*, each with its row and column, the last marked by m_tlast.
// Sizes come from the cfg_* write channel: index 0 rows of A, 1 shared dimension,
// 2 columns of B; each resets to 8, 0 acts as 1 and above 8 acts as 8.
// Each product element is formed by the single multiply-accumulate unit and its two
// memory read ports (one product per cycle) through the read and multiply pipeline;
// the next element is not started until the previous element's result is loaded.
// s_tready is high only while no compute run is in progress. A stalled m_tready
// holds the waiting result and pauses the sequencer before the next element.
// Reset clears sizes to 8 and all control state; element memories are not cleared
// and must be written by the user before they are read; the block does not enforce this.
module integer_matrix_multiply (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [imm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [imm_pkg::CFG_W-1:0]     cfg_data,
    // input items
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [23:0]                   s_tdata,  // row_index[2:0], col_index[5:3],
                                                    // element_value[21:6], zero[23:22]
    input  logic [1:0]                    s_tuser,  // operation[1:0]
    // result items
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [47:0]                   m_tdata,  // out_row[2:0], out_col[5:3],
                                                    // product_sum[40:6], zero[47:41]
    output logic                          m_tlast   // last_of_run
);
    import imm_pkg::*;

    imm_cmd_t                cmd;
    imm_stat_t               stat;
    logic [IDX_W-1:0]        out_row, out_col;
    logic signed [SUM_W-1:0] out_sum;

    assign cfg_ready = 1'b1;

    imm_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_op     (s_tuser),
        .in_ready  (s_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    imm_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .wr_row    (s_tdata[2:0]),
        .wr_col    (s_tdata[5:3]),
        .wr_value  (s_tdata[21:6]),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_sum   (out_sum),
        .out_last  (m_tlast),
        .out_valid (m_tvalid),
        .out_ready (m_tready)
    );

    assign m_tdata = {7'd0, out_sum, out_col, out_row};

endmodule

FILE: hdl/imm_ctrl.sv
// controller: size registers and the sequencer over (i, j, k)
// depends on imm_pkg; drives imm_datapath through imm_cmd_t
module imm_ctrl (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    input  logic [imm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [imm_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           in_valid,
    input  logic [imm_pkg::OP_W-1:0]       in_op,
    output logic                           in_ready,
    output imm_pkg::imm_cmd_t              cmd,
    input  imm_pkg::imm_stat_t             stat
);
    import imm_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WAIT  = 2'd1;
    localparam logic [1:0] ST_ISSUE = 2'd2;
    localparam logic [1:0] ST_DRAIN = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CFG_W-1:0] rows_reg, shared_reg, cols_reg;
    logic [IDX_W-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [IDX_W-1:0] i_last, j_last, k_last;

    assign i_last   = last_index(rows_reg);
    assign j_last   = last_index(cols_reg);
    assign k_last   = last_index(shared_reg);
    assign in_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg   <= CFG_RESET;
            shared_reg <= CFG_RESET;
            cols_reg   <= CFG_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_ROWS:   rows_reg   <= cfg_data;
                CFG_SHARED: shared_reg <= cfg_data;
                CFG_COLS:   cols_reg   <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_comb begin
        state_next   = state_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        cmd          = '0;
        cmd.a_addr   = {i_reg, k_reg};
        cmd.b_addr   = {k_reg, j_reg};
        cmd.first    = (k_reg == '0);
        cmd.last     = (k_reg == k_last);
        cmd.row      = i_reg;
        cmd.col      = j_reg;
        cmd.run_last = (i_reg == i_last) && (j_reg == j_last);
        case (state_reg)
            ST_IDLE: begin
                cmd.wr_a = in_valid && (in_op == OP_WR_A);
                cmd.wr_b = in_valid && (in_op == OP_WR_B);
                if (in_valid && (in_op == OP_COMPUTE)) begin
                    i_next     = '0;
                    j_next     = '0;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                // hold off until the output register can take this element
                if (stat.out_free) begin
                    k_next     = '0;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                cmd.rd_en = 1'b1;
                if (k_reg == k_last) begin
                    state_next = ST_DRAIN;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (stat.res_load) begin
                    if (cmd.run_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_WAIT;
                        if (j_reg == j_last) begin
                            j_next = '0;
                            i_next = i_reg + 1'b1;
                        end else begin
                            j_next = j_reg + 1'b1;
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

endmodule

FILE: hdl/imm_datapath.sv
// datapath: element memories for A and B, multiply-accumulate pipeline, output register
// depends on imm_pkg; commanded by imm_ctrl
module imm_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  imm_pkg::imm_cmd_t                 cmd,
    output imm_pkg::imm_stat_t                stat,
    input  logic [imm_pkg::IDX_W-1:0]         wr_row,
    input  logic [imm_pkg::IDX_W-1:0]         wr_col,
    input  logic signed [imm_pkg::ELEM_W-1:0] wr_value,
    output logic [imm_pkg::IDX_W-1:0]         out_row,
    output logic [imm_pkg::IDX_W-1:0]         out_col,
    output logic signed [imm_pkg::SUM_W-1:0]  out_sum,
    output logic                              out_last,
    output logic                              out_valid,
    input  logic                              out_ready
);
    import imm_pkg::*;

    logic signed [ELEM_W-1:0] mem_a [MEM_DEPTH];
    logic signed [ELEM_W-1:0] mem_b [MEM_DEPTH];
    logic [ADDR_W-1:0]        wr_addr;

    // stage 1: memory read
    logic signed [ELEM_W-1:0] a_q_reg, b_q_reg;
    logic                     s1_valid_reg, s1_first_reg, s1_last_reg, s1_end_reg;
    logic [IDX_W-1:0]         s1_row_reg, s1_col_reg;
    // stage 2: product
    logic signed [PROD_W-1:0] prod_reg;
    logic                     s2_valid_reg, s2_first_reg, s2_last_reg, s2_end_reg;
    logic [IDX_W-1:0]         s2_row_reg, s2_col_reg;
    // stage 3: accumulate
    logic signed [SUM_W-1:0]  acc_reg, acc_next;
    logic signed [SUM_W-1:0]  out_sum_reg;
    logic [IDX_W-1:0]         out_row_reg, out_col_reg;
    logic                     out_last_reg, out_valid_reg;
    logic                     res_load;

    assign wr_addr = {wr_row, wr_col};

    always_ff @(posedge aclk) begin
        if (cmd.wr_a) begin
            mem_a[wr_addr] <= wr_value;
        end
        if (cmd.wr_b) begin
            mem_b[wr_addr] <= wr_value;
        end
        if (cmd.rd_en) begin
            a_q_reg <= mem_a[cmd.a_addr];
            b_q_reg <= mem_b[cmd.b_addr];
        end
    end

    always_ff @(posedge aclk) begin
        s1_first_reg <= cmd.first;
        s1_last_reg  <= cmd.last;
        s1_end_reg   <= cmd.run_last;
        s1_row_reg   <= cmd.row;
        s1_col_reg   <= cmd.col;
        prod_reg     <= a_q_reg * b_q_reg;
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        s2_end_reg   <= s1_end_reg;
        s2_row_reg   <= s1_row_reg;
        s2_col_reg   <= s1_col_reg;
        if (s2_valid_reg) begin
            acc_reg <= acc_next;
        end
        if (res_load) begin
            out_sum_reg  <= acc_next;
            out_row_reg  <= s2_row_reg;
            out_col_reg  <= s2_col_reg;
            out_last_reg <= s2_end_reg;
        end
    end

    // restart the sum on the first product of each element
    assign acc_next = (s2_first_reg ? SUM_W'(0) : acc_reg)
                    + {{(SUM_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign res_load = s2_valid_reg && s2_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= cmd.rd_en;
            s2_valid_reg <= s1_valid_reg;
            if (res_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat = '{out_free: (!out_valid_reg || out_ready), res_load: res_load};

    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_sum   = out_sum_reg;
    assign out_last  = out_last_reg;
    assign out_valid = out_valid_reg;

    // a finished element never lands on a result that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |-> !out_valid_reg)
        else $error("result loaded while output register still full");

    // the products of one element arrive in consecutive cycles
    a_k_contiguous: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s1_first_reg) |-> $past(s1_valid_reg))
        else $error("gap inside an element's product stream");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule
